### design/rrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_pkg: shared types and constants for the request retry tracker
// Field widths, command and message codes, event codes, and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rrt_pkg;

   localparam int CACHE_DEPTH_DEF = 8;

   localparam int ID_W       = 16;
   localparam int TYPE_W     = 2;
   localparam int HANDLE_W   = 16;
   localparam int CMD_W      = 2;
   localparam int EV_W       = 4;
   localparam int ATT_W      = 4;
   localparam int TIMER_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ENTRY_W    = ID_W + TYPE_W + HANDLE_W;

   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MSG   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   localparam logic [TYPE_W-1:0] MT_ACK    = 2'd1;
   localparam logic [TYPE_W-1:0] MT_RESULT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESULT_TIMEOUT = 2'd2;

   localparam logic [ATT_W-1:0]   RETRY_LIMIT_RST    = 4'd3;
   localparam logic [TIMER_W-1:0] ACK_TIMEOUT_RST    = 16'd10;
   localparam logic [TIMER_W-1:0] RESULT_TIMEOUT_RST = 16'd50;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ACK    = 2'd1,
      PH_RESULT = 2'd2
   } phase_type;

   typedef enum logic [EV_W-1:0] {
      EV_SEND      = 4'd0,
      EV_ACK       = 4'd1,
      EV_RESULT    = 4'd2,
      EV_EXHAUSTED = 4'd3,
      EV_RTIMEOUT  = 4'd4,
      EV_CACHED    = 4'd5,
      EV_EVICTED   = 4'd6,
      EV_NONE      = 4'd7,
      EV_BUSY      = 4'd8
   } ev_type;

   typedef enum logic [2:0] {
      HS_ZERO,
      HS_ACK,
      HS_RES,
      HS_MSG,
      HS_RAM
   } hsel_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_COMP_RD,
      S_COMP_WR,
      S_ACK_DONE,
      S_EVICT_RD,
      S_STORE_WR,
      S_EM_SEND,
      S_EM_ACK,
      S_EM_RES,
      S_EM_BUSY,
      S_EM_NONE,
      S_EM_EXH,
      S_EM_RTO,
      S_EM_EVICT,
      S_EM_CACHED
   } ctl_state_type;

   typedef struct packed {
      logic     latch_in;
      logic     start_req;
      logic     retry;
      logic     tick;
      logic     enter_ack;
      logic     enter_res;
      logic     ack_from_msg;
      logic     res_from_msg;
      logic     go_idle;
      logic     srch_rd;
      logic     srch_next;
      logic     srch_hit;
      logic     comp_rd;
      logic     comp_wr;
      logic     comp_done;
      logic     evict_rd;
      logic     evict;
      logic     store_wr;
      logic     emit;
      ev_type   ev;
      hsel_type hsel;
      logic     last;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      phase_type        phase;
      logic             ack_match;
      logic             res_match;
      logic             mode_blocking;
      logic             full;
      logic             ack_expired;
      logic             res_expired;
      logic             can_retry;
      logic             srch_end;
      logic             srch_hit;
      logic             comp_end;
      logic             srch_is_ack;
      logic             send_flag;
      logic             ack_flag;
      logic             res_flag;
      logic             out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

### design/rrt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while no read is requested.
// ----------------------------------------------------------------------------
module rrt_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [AW-1:0]         waddr,
   input  wire logic [WIDTH-1:0]      wdata,
   input  wire logic                  re,
   input  wire logic [AW-1:0]         raddr,
   output logic      [WIDTH-1:0]      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### design/rrt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_dp: request tracker datapath
// Config registers, request state, elapsed timer, the ordered pending store
// (circular RAM with head pointer), search index and the result register.
// ----------------------------------------------------------------------------
module rrt_dp #(
   parameter int CACHE_DEPTH = rrt_pkg::CACHE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [rrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rrt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [rrt_pkg::CMD_W-1:0]        req_command,
   input  wire logic                             req_blocking,
   input  wire logic [rrt_pkg::ID_W-1:0]         req_msg_id,
   input  wire logic [rrt_pkg::TYPE_W-1:0]       req_msg_type,
   input  wire logic [rrt_pkg::HANDLE_W-1:0]     req_msg_handle,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [rrt_pkg::EV_W-1:0]         rsp_event_res,
   output logic      [rrt_pkg::ID_W-1:0]         rsp_req_id,
   output logic      [rrt_pkg::HANDLE_W-1:0]     rsp_handle,
   output logic      [rrt_pkg::ATT_W-1:0]        rsp_attempt,
   output logic                                  rsp_last,
   input  wire rrt_pkg::dp_cmd_type              cmd,
   output rrt_pkg::dp_stat_type                  stat
);
   localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int CW = $clog2(CACHE_DEPTH + 1);

   // map a logical position (0 = oldest) onto a RAM address
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(CACHE_DEPTH)) begin
         sum = sum - (CW+1)'(CACHE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   logic [rrt_pkg::ATT_W-1:0]    retry_limit_ff, retry_limit_in;
   logic [rrt_pkg::TIMER_W-1:0]  ack_timeout_ff, ack_timeout_in;
   logic [rrt_pkg::TIMER_W-1:0]  result_timeout_ff, result_timeout_in;

   logic [rrt_pkg::CMD_W-1:0]    cmd_ff;
   logic                         blk_ff;
   logic [rrt_pkg::ID_W-1:0]     mid_ff;
   logic [rrt_pkg::TYPE_W-1:0]   mty_ff;
   logic [rrt_pkg::HANDLE_W-1:0] mh_ff;

   rrt_pkg::phase_type           phase_ff, phase_in;
   logic                         mode_ff, mode_in;
   logic [rrt_pkg::ID_W-1:0]     cur_id_ff, cur_id_in;
   logic [rrt_pkg::TIMER_W-1:0]  elapsed_ff, elapsed_in;
   logic [rrt_pkg::ATT_W-1:0]    sends_ff, sends_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                head_ff, head_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [rrt_pkg::TYPE_W-1:0]   srch_type_ff, srch_type_in;
   logic                         send_flag_ff, send_flag_in;
   logic                         ack_flag_ff, ack_flag_in;
   logic                         res_flag_ff, res_flag_in;
   logic [rrt_pkg::HANDLE_W-1:0] ack_h_ff, ack_h_in;
   logic [rrt_pkg::HANDLE_W-1:0] res_h_ff, res_h_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rrt_pkg::EV_W-1:0]     rsp_ev_ff;
   logic [rrt_pkg::ID_W-1:0]     rsp_id_ff;
   logic [rrt_pkg::HANDLE_W-1:0] rsp_h_ff, rsp_h_sel;
   logic [rrt_pkg::ATT_W-1:0]    rsp_att_ff;
   logic                         rsp_last_ff;

   logic [rrt_pkg::TIMER_W-1:0]  elapsed_inc;
   logic [CW-1:0]                idx_plus;
   logic [CW-1:0]                rd_off, wr_off;
   logic [AW-1:0]                ram_raddr, ram_waddr;
   logic [rrt_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
   logic                         ram_re, ram_we;
   logic [rrt_pkg::ID_W-1:0]     rd_id;
   logic [rrt_pkg::TYPE_W-1:0]   rd_type;
   logic [rrt_pkg::HANDLE_W-1:0] rd_handle;
   logic                         out_free;

   assign rd_id     = ram_rdata[rrt_pkg::ENTRY_W-1 -: rrt_pkg::ID_W];
   assign rd_type   = ram_rdata[rrt_pkg::HANDLE_W +: rrt_pkg::TYPE_W];
   assign rd_handle = ram_rdata[rrt_pkg::HANDLE_W-1:0];

   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff
                                           : elapsed_ff + rrt_pkg::TIMER_W'(1);
   assign idx_plus    = idx_ff + CW'(1);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // store RAM ports
   assign ram_re    = cmd.srch_rd || cmd.comp_rd || cmd.evict_rd;
   assign rd_off    = cmd.comp_rd ? idx_plus : (cmd.evict_rd ? '0 : idx_ff);
   assign ram_raddr = phys(head_ff, rd_off);
   assign ram_we    = cmd.comp_wr || cmd.store_wr;
   assign wr_off    = cmd.store_wr ? count_ff : idx_ff;
   assign ram_waddr = phys(head_ff, wr_off);
   assign ram_wdata = cmd.store_wr ? {mid_ff, mty_ff, mh_ff} : ram_rdata;

   rrt_ram #(
      .WIDTH (rrt_pkg::ENTRY_W),
      .DEPTH (CACHE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // config registers
   always_comb begin
      retry_limit_in    = retry_limit_ff;
      ack_timeout_in    = ack_timeout_ff;
      result_timeout_in = result_timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            rrt_pkg::CSR_RETRY_LIMIT:    retry_limit_in    = csr_wdata[rrt_pkg::ATT_W-1:0];
            rrt_pkg::CSR_ACK_TIMEOUT:    ack_timeout_in    = csr_wdata;
            rrt_pkg::CSR_RESULT_TIMEOUT: result_timeout_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // request state and store bookkeeping
   always_comb begin
      phase_in     = phase_ff;
      mode_in      = mode_ff;
      cur_id_in    = cur_id_ff;
      elapsed_in   = elapsed_ff;
      sends_in     = sends_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      idx_in       = idx_ff;
      srch_type_in = srch_type_ff;
      send_flag_in = send_flag_ff;
      ack_flag_in  = ack_flag_ff;
      res_flag_in  = res_flag_ff;
      ack_h_in     = ack_h_ff;
      res_h_in     = res_h_ff;

      if (cmd.latch_in) begin
         send_flag_in = 1'b0;
         ack_flag_in  = 1'b0;
         res_flag_in  = 1'b0;
      end
      if (cmd.start_req) begin
         cur_id_in    = cur_id_ff + rrt_pkg::ID_W'(1);
         mode_in      = blk_ff;
         sends_in     = rrt_pkg::ATT_W'(1);
         send_flag_in = 1'b1;
      end
      if (cmd.retry) begin
         sends_in     = sends_ff + rrt_pkg::ATT_W'(1);
         send_flag_in = 1'b1;
      end
      if (cmd.tick) begin
         elapsed_in = elapsed_inc;
      end
      // phase entry restarts the timer and the search
      if (cmd.enter_ack) begin
         phase_in     = rrt_pkg::PH_ACK;
         elapsed_in   = '0;
         srch_type_in = rrt_pkg::MT_ACK;
         idx_in       = '0;
      end
      if (cmd.enter_res) begin
         phase_in     = rrt_pkg::PH_RESULT;
         elapsed_in   = '0;
         srch_type_in = rrt_pkg::MT_RESULT;
         idx_in       = '0;
      end
      if (cmd.go_idle) begin
         phase_in = rrt_pkg::PH_IDLE;
      end
      if (cmd.ack_from_msg) begin
         ack_flag_in = 1'b1;
         ack_h_in    = mh_ff;
      end
      if (cmd.res_from_msg) begin
         res_flag_in = 1'b1;
         res_h_in    = mh_ff;
      end
      if (cmd.srch_next || cmd.comp_wr) begin
         idx_in = idx_plus;
      end
      if (cmd.srch_hit) begin
         if (srch_type_ff == rrt_pkg::MT_ACK) begin
            ack_flag_in = 1'b1;
            ack_h_in    = rd_handle;
         end else begin
            res_flag_in = 1'b1;
            res_h_in    = rd_handle;
         end
      end
      if (cmd.comp_done || cmd.evict) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.evict) begin
         head_in = (head_ff == AW'(CACHE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
      end
      if (cmd.store_wr) begin
         count_in = count_ff + CW'(1);
      end
   end

   // result register
   always_comb begin
      case (cmd.hsel)
         rrt_pkg::HS_ACK: rsp_h_sel = ack_h_ff;
         rrt_pkg::HS_RES: rsp_h_sel = res_h_ff;
         rrt_pkg::HS_MSG: rsp_h_sel = mh_ff;
         rrt_pkg::HS_RAM: rsp_h_sel = rd_handle;
         default:         rsp_h_sel = '0;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff    <= rrt_pkg::RETRY_LIMIT_RST;
         ack_timeout_ff    <= rrt_pkg::ACK_TIMEOUT_RST;
         result_timeout_ff <= rrt_pkg::RESULT_TIMEOUT_RST;
         phase_ff          <= rrt_pkg::PH_IDLE;
         mode_ff           <= 1'b0;
         cur_id_ff         <= '0;
         elapsed_ff        <= '0;
         sends_ff          <= '0;
         count_ff          <= '0;
         head_ff           <= '0;
         idx_ff            <= '0;
         srch_type_ff      <= rrt_pkg::MT_ACK;
         send_flag_ff      <= 1'b0;
         ack_flag_ff       <= 1'b0;
         res_flag_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         retry_limit_ff    <= retry_limit_in;
         ack_timeout_ff    <= ack_timeout_in;
         result_timeout_ff <= result_timeout_in;
         phase_ff          <= phase_in;
         mode_ff           <= mode_in;
         cur_id_ff         <= cur_id_in;
         elapsed_ff        <= elapsed_in;
         sends_ff          <= sends_in;
         count_ff          <= count_in;
         head_ff           <= head_in;
         idx_ff            <= idx_in;
         srch_type_ff      <= srch_type_in;
         send_flag_ff      <= send_flag_in;
         ack_flag_ff       <= ack_flag_in;
         res_flag_ff       <= res_flag_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ack_h_ff <= ack_h_in;
      res_h_ff <= res_h_in;
      if (cmd.latch_in) begin
         cmd_ff <= req_command;
         blk_ff <= req_blocking;
         mid_ff <= req_msg_id;
         mty_ff <= req_msg_type;
         mh_ff  <= req_msg_handle;
      end
      if (cmd.emit) begin
         rsp_ev_ff   <= cmd.ev;
         rsp_id_ff   <= cur_id_ff;
         rsp_h_ff    <= rsp_h_sel;
         rsp_att_ff  <= sends_ff;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_ev_ff;
   assign rsp_req_id    = rsp_id_ff;
   assign rsp_handle    = rsp_h_ff;
   assign rsp_attempt   = rsp_att_ff;
   assign rsp_last      = rsp_last_ff;

   // status to the controller
   always_comb begin
      stat.cmd           = cmd_ff;
      stat.phase         = phase_ff;
      stat.ack_match     = (phase_ff == rrt_pkg::PH_ACK) && (mid_ff == cur_id_ff)
                           && (mty_ff == rrt_pkg::MT_ACK);
      stat.res_match     = (phase_ff == rrt_pkg::PH_RESULT) && (mid_ff == cur_id_ff)
                           && (mty_ff == rrt_pkg::MT_RESULT);
      stat.mode_blocking = mode_ff;
      stat.full          = (count_ff == CW'(CACHE_DEPTH));
      stat.ack_expired   = (elapsed_inc >= ack_timeout_ff);
      stat.res_expired   = (elapsed_inc >= result_timeout_ff);
      stat.can_retry     = (sends_ff < retry_limit_ff);
      stat.srch_end      = (idx_ff >= count_ff);
      stat.srch_hit      = (rd_id == cur_id_ff) && (rd_type == srch_type_ff);
      stat.comp_end      = ((CW+1)'(idx_ff) + (CW+1)'(1)) >= (CW+1)'(count_ff);
      stat.srch_is_ack   = (srch_type_ff == rrt_pkg::MT_ACK);
      stat.send_flag     = send_flag_ff;
      stat.ack_flag      = ack_flag_ff;
      stat.res_flag      = res_flag_ff;
      stat.out_free      = out_free;
   end

endmodule
`default_nettype wire

### design/rrt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_ctrl: request tracker sequencer
// Decodes each item, walks the pending store for searches, compaction and
// eviction, and issues the result items one at a time.
// ----------------------------------------------------------------------------
module rrt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire rrt_pkg::dp_stat_type  stat,
   output rrt_pkg::dp_cmd_type        cmd
);
   rrt_pkg::ctl_state_type state_ff, state_in;
   rrt_pkg::ctl_state_type em_first;

   // first result of a send / ack / result chain
   always_comb begin
      if (stat.send_flag) begin
         em_first = rrt_pkg::S_EM_SEND;
      end else if (stat.ack_flag) begin
         em_first = rrt_pkg::S_EM_ACK;
      end else begin
         em_first = rrt_pkg::S_EM_RES;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrt_pkg::S_IDLE: begin
            if (req_valid) state_in = rrt_pkg::S_DECODE;
         end
         rrt_pkg::S_DECODE: begin
            if (stat.cmd == rrt_pkg::CMD_START) begin
               state_in = (stat.phase != rrt_pkg::PH_IDLE) ? rrt_pkg::S_EM_BUSY
                                                          : rrt_pkg::S_SRCH_RD;
            end else if (stat.cmd == rrt_pkg::CMD_MSG) begin
               if (stat.ack_match) begin
                  state_in = rrt_pkg::S_ACK_DONE;
               end else if (stat.res_match) begin
                  state_in = rrt_pkg::S_EM_RES;
               end else if (stat.full) begin
                  state_in = rrt_pkg::S_EVICT_RD;
               end else begin
                  state_in = rrt_pkg::S_STORE_WR;
               end
            end else if (stat.cmd == rrt_pkg::CMD_TICK && stat.phase != rrt_pkg::PH_IDLE) begin
               if (stat.phase == rrt_pkg::PH_ACK) begin
                  if (!stat.ack_expired) begin
                     state_in = rrt_pkg::S_EM_NONE;
                  end else if (stat.can_retry) begin
                     state_in = rrt_pkg::S_SRCH_RD;
                  end else begin
                     state_in = rrt_pkg::S_EM_EXH;
                  end
               end else begin
                  state_in = stat.res_expired ? rrt_pkg::S_EM_RTO : rrt_pkg::S_EM_NONE;
               end
            end else begin
               state_in = rrt_pkg::S_EM_NONE;
            end
         end
         rrt_pkg::S_SRCH_RD: begin
            state_in = stat.srch_end ? em_first : rrt_pkg::S_SRCH_CMP;
         end
         rrt_pkg::S_SRCH_CMP: begin
            state_in = stat.srch_hit ? rrt_pkg::S_COMP_RD : rrt_pkg::S_SRCH_RD;
         end
         rrt_pkg::S_COMP_RD: begin
            if (stat.comp_end) begin
               state_in = stat.srch_is_ack ? rrt_pkg::S_ACK_DONE : em_first;
            end else begin
               state_in = rrt_pkg::S_COMP_WR;
            end
         end
         rrt_pkg::S_COMP_WR:  state_in = rrt_pkg::S_COMP_RD;
         rrt_pkg::S_ACK_DONE: begin
            state_in = stat.mode_blocking ? rrt_pkg::S_SRCH_RD : em_first;
         end
         rrt_pkg::S_EVICT_RD: state_in = rrt_pkg::S_EM_EVICT;
         rrt_pkg::S_EM_EVICT: begin
            if (stat.out_free) state_in = rrt_pkg::S_STORE_WR;
         end
         rrt_pkg::S_STORE_WR: state_in = rrt_pkg::S_EM_CACHED;
         rrt_pkg::S_EM_SEND: begin
            if (stat.out_free) state_in = stat.ack_flag ? rrt_pkg::S_EM_ACK : rrt_pkg::S_IDLE;
         end
         rrt_pkg::S_EM_ACK: begin
            if (stat.out_free) state_in = stat.res_flag ? rrt_pkg::S_EM_RES : rrt_pkg::S_IDLE;
         end
         rrt_pkg::S_EM_RES, rrt_pkg::S_EM_BUSY, rrt_pkg::S_EM_NONE,
         rrt_pkg::S_EM_EXH, rrt_pkg::S_EM_RTO, rrt_pkg::S_EM_CACHED: begin
            if (stat.out_free) state_in = rrt_pkg::S_IDLE;
         end
         default: state_in = rrt_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.ev    = rrt_pkg::EV_NONE;
      cmd.hsel  = rrt_pkg::HS_ZERO;
      req_ready = 1'b0;
      unique case (state_ff)
         rrt_pkg::S_IDLE: begin
            req_ready    = 1'b1;
            cmd.latch_in = req_valid;
         end
         rrt_pkg::S_DECODE: begin
            if (stat.cmd == rrt_pkg::CMD_START) begin
               if (stat.phase == rrt_pkg::PH_IDLE) begin
                  cmd.start_req = 1'b1;
                  cmd.enter_ack = 1'b1;
               end
            end else if (stat.cmd == rrt_pkg::CMD_MSG) begin
               if (stat.ack_match) begin
                  cmd.ack_from_msg = 1'b1;
               end else if (stat.res_match) begin
                  cmd.res_from_msg = 1'b1;
                  cmd.go_idle      = 1'b1;
               end
            end else if (stat.cmd == rrt_pkg::CMD_TICK && stat.phase != rrt_pkg::PH_IDLE) begin
               cmd.tick = 1'b1;
               if (stat.phase == rrt_pkg::PH_ACK) begin
                  if (stat.ack_expired) begin
                     if (stat.can_retry) begin
                        cmd.retry     = 1'b1;
                        cmd.enter_ack = 1'b1;
                     end else begin
                        cmd.go_idle = 1'b1;
                     end
                  end
               end else if (stat.res_expired) begin
                  cmd.go_idle = 1'b1;
               end
            end
         end
         rrt_pkg::S_SRCH_RD: begin
            cmd.srch_rd = !stat.srch_end;
         end
         rrt_pkg::S_SRCH_CMP: begin
            cmd.srch_hit  = stat.srch_hit;
            cmd.srch_next = !stat.srch_hit;
         end
         rrt_pkg::S_COMP_RD: begin
            if (stat.comp_end) begin
               cmd.comp_done = 1'b1;
               cmd.go_idle   = !stat.srch_is_ack;
            end else begin
               cmd.comp_rd = 1'b1;
            end
         end
         rrt_pkg::S_COMP_WR: cmd.comp_wr = 1'b1;
         rrt_pkg::S_ACK_DONE: begin
            if (stat.mode_blocking) begin
               cmd.enter_res = 1'b1;
            end else begin
               cmd.go_idle = 1'b1;
            end
         end
         rrt_pkg::S_EVICT_RD: cmd.evict_rd = 1'b1;
         rrt_pkg::S_STORE_WR: cmd.store_wr = 1'b1;
         rrt_pkg::S_EM_EVICT: begin
            cmd.emit  = stat.out_free;
            cmd.evict = stat.out_free;
            cmd.ev    = rrt_pkg::EV_EVICTED;
            cmd.hsel  = rrt_pkg::HS_RAM;
         end
         rrt_pkg::S_EM_CACHED: begin
            cmd.emit = stat.out_free;
            cmd.ev   = rrt_pkg::EV_CACHED;
            cmd.hsel = rrt_pkg::HS_MSG;
            cmd.last = 1'b1;
         end
         rrt_pkg::S_EM_SEND: begin
            cmd.emit = stat.out_free;
            cmd.ev   = rrt_pkg::EV_SEND;
            cmd.last = !stat.ack_flag;
         end
         rrt_pkg::S_EM_ACK: begin
            cmd.emit = stat.out_free;
            cmd.ev   = rrt_pkg::EV_ACK;
            cmd.hsel = rrt_pkg::HS_ACK;
            cmd.last = !stat.res_flag;
         end
         rrt_pkg::S_EM_RES: begin
            cmd.emit = stat.out_free;
            cmd.ev   = rrt_pkg::EV_RESULT;
            cmd.hsel = rrt_pkg::HS_RES;
            cmd.last = 1'b1;
         end
         rrt_pkg::S_EM_BUSY: begin
            cmd.emit = stat.out_free;
            cmd.ev   = rrt_pkg::EV_BUSY;
            cmd.last = 1'b1;
         end
         rrt_pkg::S_EM_NONE: begin
            cmd.emit = stat.out_free;
            cmd.ev   = rrt_pkg::EV_NONE;
            cmd.last = 1'b1;
         end
         rrt_pkg::S_EM_EXH: begin
            cmd.emit = stat.out_free;
            cmd.ev   = rrt_pkg::EV_EXHAUSTED;
            cmd.last = 1'b1;
         end
         rrt_pkg::S_EM_RTO: begin
            cmd.emit = stat.out_free;
            cmd.ev   = rrt_pkg::EV_RTIMEOUT;
            cmd.last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### design/request_retry_tracker_with_reorder_cache.sv
`default_nettype none
// Flow: an accepted item is registered, then decoded in S_DECODE; a store search reads and
// compares each entry scanned (S_SRCH_RD, S_SRCH_CMP) and reads and writes back each entry
// moved up behind a hit (S_COMP_RD, S_COMP_WR), over the one RAM read port; send, ack and
// result items leave in that order, each once the output is free; an evicted item leaves
// ahead of the cached one. One item at a time: a new one is accepted only in S_IDLE.
// Reset: synchronous; config returns to defaults and the store empties at once, no sweep.
// ----------------------------------------------------------------------------
// request_retry_tracker_with_reorder_cache: stop-and-wait request tracker
// Assigns request ids, times acknowledgement and result waits with retries,
// and keeps unmatched messages in an ordered pending store.
// ----------------------------------------------------------------------------
module request_retry_tracker_with_reorder_cache #(
   parameter int CACHE_DEPTH = rrt_pkg::CACHE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [rrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rrt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [rrt_pkg::CMD_W-1:0]        req_command,
   input  wire logic                             req_blocking,
   input  wire logic [rrt_pkg::ID_W-1:0]         req_msg_id,
   input  wire logic [rrt_pkg::TYPE_W-1:0]       req_msg_type,
   input  wire logic [rrt_pkg::HANDLE_W-1:0]     req_msg_handle,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [rrt_pkg::EV_W-1:0]         rsp_event_res,
   output logic      [rrt_pkg::ID_W-1:0]         rsp_req_id,
   output logic      [rrt_pkg::HANDLE_W-1:0]     rsp_handle,
   output logic      [rrt_pkg::ATT_W-1:0]        rsp_attempt,
   output logic                                  rsp_last
);
   rrt_pkg::dp_cmd_type  dp_cmd;
   rrt_pkg::dp_stat_type dp_stat;

   rrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   rrt_dp #(
      .CACHE_DEPTH (CACHE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_command    (req_command),
      .req_blocking   (req_blocking),
      .req_msg_id     (req_msg_id),
      .req_msg_type   (req_msg_type),
      .req_msg_handle (req_msg_handle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_res  (rsp_event_res),
      .rsp_req_id     (rsp_req_id),
      .rsp_handle     (rsp_handle),
      .rsp_attempt    (rsp_attempt),
      .rsp_last       (rsp_last),
      .cmd            (dp_cmd),
      .stat           (dp_stat)
   );

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: request retry tracker with reorder cache
// Drives start, message, tick and spare commands through the request channel
// with random gaps. A behavioral tracker model predicts every result item at
// acceptance. A checking process compares each result item with the oldest
// prediction. The register settings change between phases while the block is
// idle, including zero, masked and maximum values.
// ----------------------------------------------------------------------------
module testbench;
   import rrt_pkg::*;

   localparam int DEPTH = CACHE_DEPTH_DEF;
   localparam int SETTLE_CYCLES = 4 * DEPTH + 12;

   localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
   localparam logic [TYPE_W-1:0]    MT_REQUEST  = 2'd0;
   localparam logic [TYPE_W-1:0]    MT_SPARE    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG  = 2'd3;

   typedef struct packed {
      ev_type               ev;
      logic [ID_W-1:0]      id;
      logic [HANDLE_W-1:0]  handle;
      logic [ATT_W-1:0]     attempt;
      logic                 last;
   } rsp_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_command = '0;
   logic                  req_blocking = 1'b0;
   logic [ID_W-1:0]       req_msg_id = '0;
   logic [TYPE_W-1:0]     req_msg_type = '0;
   logic [HANDLE_W-1:0]   req_msg_handle = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [EV_W-1:0]       rsp_event_res;
   logic [ID_W-1:0]       rsp_req_id;
   logic [HANDLE_W-1:0]   rsp_handle;
   logic [ATT_W-1:0]      rsp_attempt;
   logic                  rsp_last;

   request_retry_tracker_with_reorder_cache dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_blocking   (req_blocking),
      .req_msg_id     (req_msg_id),
      .req_msg_type   (req_msg_type),
      .req_msg_handle (req_msg_handle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_res  (rsp_event_res),
      .rsp_req_id     (rsp_req_id),
      .rsp_handle     (rsp_handle),
      .rsp_attempt    (rsp_attempt),
      .rsp_last       (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // tracker model state and settings
   logic [ATT_W-1:0]    trk_retry_limit;
   logic [TIMER_W-1:0]  trk_ack_timeout;
   logic [TIMER_W-1:0]  trk_result_timeout;
   phase_type           trk_phase;
   logic                trk_blocking;
   logic [ID_W-1:0]     trk_cur_id;
   logic [TIMER_W-1:0]  trk_elapsed;
   logic [ATT_W-1:0]    trk_sends;
   logic [ID_W-1:0]     pend_id [DEPTH];
   logic [TYPE_W-1:0]   pend_type [DEPTH];
   logic [HANDLE_W-1:0] pend_handle [DEPTH];
   int                  pend_count;

   rsp_item_type expected_rsp_q[$];
   int           mismatch_count = 0;
   int           items_sent = 0;
   bit           req_idle_en = 1'b1;
   bit           rsp_idle_en = 1'b1;
   int           rsp_hold_cycles = 0;

   function automatic void note_rsp(ev_type ev, logic [HANDLE_W-1:0] h);
      rsp_item_type item;
      item.ev = ev;
      item.id = trk_cur_id;
      item.handle = h;
      item.attempt = trk_sends;
      item.last = 1'b0;
      expected_rsp_q.push_back(item);
   endfunction

   // oldest-first search; close up the store behind a hit
   function automatic bit store_take(input logic [ID_W-1:0] id, input logic [TYPE_W-1:0] ty,
                                     output logic [HANDLE_W-1:0] h);
      int i;
      int j;
      h = '0;
      for (i = 0; i < pend_count; i++) begin
         if (pend_id[i] == id && pend_type[i] == ty) begin
            h = pend_handle[i];
            for (j = i; j + 1 < pend_count; j++) begin
               pend_id[j] = pend_id[j + 1];
               pend_type[j] = pend_type[j + 1];
               pend_handle[j] = pend_handle[j + 1];
            end
            pend_count--;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void store_put(logic [ID_W-1:0] id, logic [TYPE_W-1:0] ty,
                                     logic [HANDLE_W-1:0] h);
      int j;
      if (pend_count >= DEPTH) begin
         note_rsp(EV_EVICTED, pend_handle[0]);
         for (j = 0; j + 1 < DEPTH; j++) begin
            pend_id[j] = pend_id[j + 1];
            pend_type[j] = pend_type[j + 1];
            pend_handle[j] = pend_handle[j + 1];
         end
         pend_count = DEPTH - 1;
      end
      pend_id[pend_count] = id;
      pend_type[pend_count] = ty;
      pend_handle[pend_count] = h;
      pend_count++;
      note_rsp(EV_CACHED, h);
   endfunction

   function automatic void accept_ack(logic [HANDLE_W-1:0] h);
      logic [HANDLE_W-1:0] r;
      note_rsp(EV_ACK, h);
      if (trk_blocking) begin
         trk_phase = PH_RESULT;
         trk_elapsed = '0;
         if (store_take(trk_cur_id, MT_RESULT, r)) begin
            note_rsp(EV_RESULT, r);
            trk_phase = PH_IDLE;
         end
      end else begin
         trk_phase = PH_IDLE;
      end
   endfunction

   function automatic void open_ack_wait();
      logic [HANDLE_W-1:0] h;
      trk_phase = PH_ACK;
      trk_elapsed = '0;
      if (store_take(trk_cur_id, MT_ACK, h))
         accept_ack(h);
   endfunction

   function automatic void tracker_predict(logic [CMD_W-1:0] cmd, logic blk,
                                           logic [ID_W-1:0] mid, logic [TYPE_W-1:0] mty,
                                           logic [HANDLE_W-1:0] mh);
      rsp_item_type tail;
      if (cmd == CMD_START) begin
         if (trk_phase != PH_IDLE) begin
            note_rsp(EV_BUSY, '0);
         end else begin
            trk_cur_id = trk_cur_id + 16'd1;
            trk_blocking = blk;
            trk_sends = 4'd1;
            note_rsp(EV_SEND, '0);
            open_ack_wait();
         end
      end else if (cmd == CMD_MSG) begin
         if (trk_phase == PH_ACK && mid == trk_cur_id && mty == MT_ACK) begin
            accept_ack(mh);
         end else if (trk_phase == PH_RESULT && mid == trk_cur_id && mty == MT_RESULT) begin
            note_rsp(EV_RESULT, mh);
            trk_phase = PH_IDLE;
         end else begin
            store_put(mid, mty, mh);
         end
      end else if (cmd == CMD_TICK && trk_phase != PH_IDLE) begin
         if (trk_elapsed != 16'hFFFF)
            trk_elapsed = trk_elapsed + 16'd1;
         if (trk_phase == PH_ACK) begin
            if (trk_elapsed >= trk_ack_timeout) begin
               if (trk_sends < trk_retry_limit) begin
                  trk_sends = trk_sends + 4'd1;
                  note_rsp(EV_SEND, '0);
                  open_ack_wait();
               end else begin
                  note_rsp(EV_EXHAUSTED, '0);
                  trk_phase = PH_IDLE;
               end
            end else begin
               note_rsp(EV_NONE, '0);
            end
         end else begin
            if (trk_elapsed >= trk_result_timeout) begin
               note_rsp(EV_RTIMEOUT, '0);
               trk_phase = PH_IDLE;
            end else begin
               note_rsp(EV_NONE, '0);
            end
         end
      end else begin
         note_rsp(EV_NONE, '0);
      end
      tail = expected_rsp_q.pop_back();
      tail.last = 1'b1;
      expected_rsp_q.push_back(tail);
   endfunction

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic blk,
                            input logic [ID_W-1:0] mid, input logic [TYPE_W-1:0] mty,
                            input logic [HANDLE_W-1:0] mh);
      if (req_idle_en && $urandom_range(0, 3) == 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(1, 17) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_blocking <= blk;
      req_msg_id <= mid;
      req_msg_type <= mty;
      req_msg_handle <= mh;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker_predict(cmd, blk, mid, mty, mh);
      items_sent++;
   endtask

   // drop valid and hold until every predicted item has come back
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_RETRY_LIMIT:    trk_retry_limit = data[ATT_W-1:0];
         CSR_ACK_TIMEOUT:    trk_ack_timeout = data;
         CSR_RESULT_TIMEOUT: trk_result_timeout = data;
         default: ;
      endcase
      @(negedge clock) csr_we <= 1'b0;
   endtask

   function automatic logic [ID_W-1:0] pick_msg_id();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return 16'h0000;
      else if (pick == 1)
         return 16'hFFFF;
      else if (pick < 6)
         return trk_cur_id + 16'($urandom_range(0, 2)) - 16'd1;
      return 16'($urandom);
   endfunction

   task automatic test_idle_commands();
      send_item(CMD_TICK, 1'b0, 16'h0000, MT_REQUEST, 16'h0000);
      send_item(CMD_SPARE, 1'b1, 16'hFFFF, MT_SPARE, 16'hFFFF);
      send_item(CMD_MSG, 1'b1, 16'hFFFF, MT_SPARE, 16'hFFFF);
      send_item(CMD_MSG, 1'b0, 16'h0000, MT_REQUEST, 16'h0000);
   endtask

   task automatic test_basic_exchange();
      send_item(CMD_START, 1'b0, 16'hFFFF, MT_SPARE, 16'hFFFF);
      send_item(CMD_MSG, 1'b0, trk_cur_id, MT_ACK, 16'h1234);
      send_item(CMD_START, 1'b1, 16'h0000, MT_REQUEST, 16'h0000);
      send_item(CMD_START, 1'b0, 16'h5A5A, MT_ACK, 16'hA5A5);
      send_item(CMD_TICK, 1'b1, 16'hFFFF, MT_RESULT, 16'hFFFF);
      send_item(CMD_MSG, 1'b1, trk_cur_id, MT_ACK, 16'hFFFF);
      send_item(CMD_MSG, 1'b0, trk_cur_id + 16'd1, MT_RESULT, 16'h0F0F);
      send_item(CMD_MSG, 1'b0, trk_cur_id, MT_RESULT, 16'hF0F0);
   endtask

   task automatic test_timeouts();
      wait_idle();
      csr_write(CSR_RETRY_LIMIT, 16'd2);
      csr_write(CSR_ACK_TIMEOUT, 16'd1);
      csr_write(CSR_RESULT_TIMEOUT, 16'd1);
      send_item(CMD_START, 1'b0, '0, MT_REQUEST, '0);
      send_item(CMD_TICK, 1'b0, '0, MT_REQUEST, '0);
      send_item(CMD_TICK, 1'b0, '0, MT_REQUEST, '0);
      send_item(CMD_START, 1'b1, '0, MT_REQUEST, '0);
      send_item(CMD_MSG, 1'b0, trk_cur_id, MT_ACK, 16'h00FF);
      send_item(CMD_TICK, 1'b0, '0, MT_REQUEST, '0);
   endtask

   // ack and result already waiting when the start comes
   task automatic test_stored_hits();
      send_item(CMD_MSG, 1'b0, trk_cur_id + 16'd1, MT_ACK, 16'hBEEF);
      send_item(CMD_MSG, 1'b0, trk_cur_id + 16'd1, MT_RESULT, 16'hCAFE);
      send_item(CMD_START, 1'b1, '0, MT_REQUEST, '0);
   endtask

   task automatic test_store_overflow();
      repeat (DEPTH + 2)
         send_item(CMD_MSG, 1'($urandom_range(0, 1)), 16'($urandom),
                   2'($urandom_range(0, 3)), 16'($urandom));
   endtask

   task automatic run_request_flow(input int max_steps);
      int steps;
      int k;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         send_item(CMD_MSG, 1'($urandom_range(0, 1)), trk_cur_id + 16'd1, MT_ACK,
                   16'($urandom));
      else if (pick == 1)
         send_item(CMD_MSG, 1'($urandom_range(0, 1)), trk_cur_id + 16'd1, MT_RESULT,
                   16'($urandom));
      send_item(CMD_START, 1'($urandom_range(0, 1)), 16'($urandom),
                2'($urandom_range(0, 3)), 16'($urandom));
      steps = $urandom_range(1, max_steps);
      for (k = 0; k < steps; k++) begin
         if (trk_phase == PH_IDLE && $urandom_range(0, 3) != 0)
            break;
         pick = $urandom_range(0, 99);
         if (pick < 45)
            send_item(CMD_TICK, 1'($urandom_range(0, 1)), 16'($urandom),
                      2'($urandom_range(0, 3)), 16'($urandom));
         else if (pick < 65)
            send_item(CMD_MSG, 1'($urandom_range(0, 1)), trk_cur_id,
                      (trk_phase == PH_RESULT) ? MT_RESULT : MT_ACK, 16'($urandom));
         else if (pick < 85)
            send_item(CMD_MSG, 1'($urandom_range(0, 1)), pick_msg_id(),
                      2'($urandom_range(0, 3)), 16'($urandom));
         else if (pick < 93)
            send_item(CMD_START, 1'($urandom_range(0, 1)), 16'($urandom),
                      2'($urandom_range(0, 3)), 16'($urandom));
         else
            send_item(CMD_SPARE, 1'($urandom_range(0, 1)), 16'($urandom),
                      2'($urandom_range(0, 3)), 16'($urandom));
      end
   endtask

   task automatic test_random_setting(input logic [CSR_DATA_W-1:0] retry_w,
                                      input logic [CSR_DATA_W-1:0] ack_w,
                                      input logic [CSR_DATA_W-1:0] res_w,
                                      input int n_items, input int max_steps);
      int goal;
      wait_idle();
      csr_write(CSR_RETRY_LIMIT, retry_w);
      csr_write(CSR_ACK_TIMEOUT, ack_w);
      csr_write(CSR_RESULT_TIMEOUT, res_w);
      goal = items_sent + n_items;
      while (items_sent < goal)
         run_request_flow(max_steps);
   endtask

   // receiver stalls long enough for the block to back up into the request side
   task automatic test_output_stall();
      wait_idle();
      rsp_hold_cycles = 400;
      send_item(CMD_START, 1'b1, '0, MT_REQUEST, '0);
      repeat (15) begin
         if ($urandom_range(0, 1) == 0)
            send_item(CMD_TICK, 1'b0, '0, MT_REQUEST, '0);
         else
            send_item(CMD_MSG, 1'b0, pick_msg_id(), 2'($urandom_range(0, 3)), 16'($urandom));
      end
      wait_idle();
   endtask

   task automatic test_unused_index();
      wait_idle();
      csr_write(CSR_NO_REG, 16'($urandom));
      repeat (6)
         send_item(CMD_TICK, 1'b0, '0, MT_REQUEST, '0);
   endtask

   initial begin : rsp_side
      int n;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected result item: event_res %0d req_id %0d", rsp_event_res,
                   rsp_req_id);
            mismatch_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_event_res !== want.ev) begin
               $error("event_res: expected %0d, actual %0d", want.ev, rsp_event_res);
               mismatch_count++;
            end
            if (rsp_req_id !== want.id) begin
               $error("req_id: expected %0d, actual %0d", want.id, rsp_req_id);
               mismatch_count++;
            end
            if (rsp_handle !== want.handle) begin
               $error("handle: expected %0d, actual %0d", want.handle, rsp_handle);
               mismatch_count++;
            end
            if (rsp_attempt !== want.attempt) begin
               $error("attempt: expected %0d, actual %0d", want.attempt, rsp_attempt);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      trk_retry_limit = RETRY_LIMIT_RST;
      trk_ack_timeout = ACK_TIMEOUT_RST;
      trk_result_timeout = RESULT_TIMEOUT_RST;
      trk_phase = PH_IDLE;
      trk_blocking = 1'b0;
      trk_cur_id = '0;
      trk_elapsed = '0;
      trk_sends = '0;
      pend_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_idle_commands();
      test_basic_exchange();
      test_timeouts();
      test_stored_hits();
      test_store_overflow();
      test_output_stall();
      test_random_setting(16'd3, 16'd10, 16'd50, 30, 16);
      test_random_setting(16'd1, 16'd1, 16'd1, 25, 6);
      test_random_setting(16'hFFFF, 16'd2, 16'd3, 30, 12);
      test_random_setting(16'hFFF0, 16'd0, 16'd0, 20, 6);
      test_unused_index();
      test_random_setting(16'd2, 16'hFFFF, 16'hFFFF, 20, 8);
      // finish with no idling on either side
      wait_idle();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      test_random_setting(16'd4, 16'd3, 16'd4, 35, 10);

      wait_idle();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### files.f
design/rrt_pkg.sv
design/rrt_ram.sv
design/rrt_dp.sv
design/rrt_ctrl.sv
design/request_retry_tracker_with_reorder_cache.sv
sim/testbench.sv
